### rtl/assert_macros.svh
// Assertion macros shared by the merge sorter RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/msort_pkg.sv
// Package for the merge sorter: sizes and queue entry type.
// No dependencies.
`default_nettype none
package msort_pkg;
    localparam int MAX_ELEMENTS = 64;
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = AW + 1;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    typedef struct packed {
        logic [63:0] value;
        logic        is_last;
    } t_item;
endpackage
`default_nettype wire

### rtl/msort_queue.sv
// Short queue between front end and sort engine.
// Depends on msort_pkg.
`default_nettype none
module msort_queue
    import msort_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_item,
    output logic  o_full,
    input  wire   i_pop,
    output t_item o_item,
    output logic  o_empty
);
    t_item r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0] r_cnt;

    assign o_full = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push && !o_full) - (QAW+1)'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

### rtl/msort_engine.sv
// Sort engine: loads items, bottom-up merge passes between two stores, drains.
// Depends on msort_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module msort_engine
    import msort_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_item       i_item,
    input  wire         i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [63:0] o_value,
    output logic        o_last,
    output logic        o_dropped
);
    typedef enum logic [2:0] {S_LOAD, S_MINIT, S_MRD, S_MCMP, S_DRD, S_DOUT} t_state;
    t_state r_state;
    logic [63:0] r_ma [MAX_ELEMENTS];
    logic [63:0] r_mb [MAX_ELEMENTS];
    logic [CW-1:0] r_n, r_w, r_lo, r_i, r_j, r_k, r_mid, r_hi;
    logic r_src_b, r_ovf;
    logic [63:0] r_ra_a, r_ra_b, r_rb_a, r_rb_b;
    logic [AW-1:0] n_ai, n_aj;
    logic [63:0] w_x, w_y;
    logic w_take_i;
    logic [CW:0] w_lo2, w_mid2, w_hi2;

    assign o_pop = (r_state == S_LOAD) && !i_empty;
    assign w_x = r_src_b ? r_rb_a : r_ra_a;
    assign w_y = r_src_b ? r_rb_b : r_ra_b;
    assign w_take_i = (r_i < r_mid) &&
        ((r_j >= r_hi) || ($signed(w_x) <= $signed(w_y)));

    always_comb begin
        w_lo2 = {1'b0, r_lo} + {1'b0, r_w} + {1'b0, r_w};
        w_mid2 = w_lo2 + {1'b0, r_w};
        w_hi2 = w_mid2 + {1'b0, r_w};
        n_ai = r_i[AW-1:0];
        n_aj = r_j[AW-1:0];
        if (r_state == S_MCMP) begin
            if (w_take_i) n_ai = r_i[AW-1:0] + 1'b1;
            else n_aj = r_j[AW-1:0] + 1'b1;
        end
        if (r_state == S_DRD) n_ai = r_k[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_ra_a <= r_ma[n_ai];
        r_ra_b <= r_ma[n_aj];
        r_rb_a <= r_mb[n_ai];
        r_rb_b <= r_mb[n_aj];
        if (r_state == S_LOAD && !i_empty && r_n < CW'(MAX_ELEMENTS))
            r_ma[r_n[AW-1:0]] <= i_item.value;
        if (r_state == S_MCMP) begin
            if (r_src_b) r_ma[r_k[AW-1:0]] <= w_take_i ? w_x : w_y;
            else r_mb[r_k[AW-1:0]] <= w_take_i ? w_x : w_y;
        end
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n <= '0;
            r_ovf <= 1'b0;
            o_valid <= 1'b0;
            r_src_b <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: if (!i_empty) begin
                    if (r_n < CW'(MAX_ELEMENTS)) r_n <= r_n + 1'b1;
                    else r_ovf <= 1'b1;
                    if (i_item.is_last) begin
                        if (r_n >= CW'(MAX_ELEMENTS)) r_ovf <= 1'b1;
                        r_w <= CW'(1);
                        r_src_b <= 1'b0;
                        r_state <= S_MINIT;
                    end
                end
                S_MINIT: begin
                    r_lo <= '0;
                    r_i <= '0;
                    r_k <= '0;
                    r_mid <= (r_w < r_n) ? r_w : r_n;
                    r_j <= (r_w < r_n) ? r_w : r_n;
                    r_hi <= ({1'b0, r_w, 1'b0} < {2'b0, r_n}) ? {r_w[CW-2:0], 1'b0} : r_n;
                    r_state <= (r_w < r_n) ? S_MRD : S_DRD;
                    if (!(r_w < r_n)) r_k <= '0;
                end
                S_MRD: r_state <= S_MCMP;
                S_MCMP: begin
                    if (w_take_i) r_i <= r_i + 1'b1;
                    else r_j <= r_j + 1'b1;
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 == r_hi) begin
                        if (r_hi == r_n) begin
                            r_src_b <= !r_src_b;
                            r_w <= {r_w[CW-2:0], 1'b0};
                            r_state <= S_MINIT;
                        end else begin
                            r_lo <= w_lo2[CW-1:0];
                            r_i <= w_lo2[CW-1:0];
                            r_k <= w_lo2[CW-1:0];
                            r_mid <= (w_mid2 < {1'b0, r_n}) ? w_mid2[CW-1:0] : r_n;
                            r_j <= (w_mid2 < {1'b0, r_n}) ? w_mid2[CW-1:0] : r_n;
                            r_hi <= (w_hi2 < {1'b0, r_n}) ? w_hi2[CW-1:0] : r_n;
                            r_state <= S_MRD;
                        end
                    end
                end
                S_DRD: begin
                    r_i <= r_k;
                    r_state <= S_DOUT;
                end
                S_DOUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_value <= w_x;
                        o_last <= (r_k + 1'b1 == r_n);
                        o_dropped <= r_ovf;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last) begin
                            r_n <= '0;
                            r_ovf <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_state <= S_DRD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `ASSERT_IMPL(a_pop_load, i_clk, i_rst_n, o_pop, r_state == S_LOAD)
    `ASSERT_IMPL(a_valid_dout, i_clk, i_rst_n, o_valid, r_state == S_DOUT)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_value))
endmodule
`default_nettype wire

### rtl/merge_sorter_top.sv
// Merge sorter top level: front queue feeding the sort engine.
// Depends on msort_pkg, msort_queue, msort_engine.
//
// Usage: send values on the s_axis channel, one transfer per value; tlast ends
// the set. Up to 64 values are held; more before tlast are discarded and every
// result of the set then carries the dropped flag. After tlast the engine runs
// ceil(log2(n)) merge passes through a single-write store pair, then drains n
// results on m_axis, tlast on the final one. Loading takes a value from the
// queue whenever it holds one. The four-entry input queue keeps accepting
// while the engine sorts, until it is full. A stalled receiver holds the
// result steady. Synchronous active-low reset empties the queue and the held
// set; store contents are not cleared.
`default_nettype none
module merge_sorter_top
    import msort_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // value
    input  wire         s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sorted_value
    output logic        m_axis_tlast,   // end_of_run
    output logic        m_axis_tuser    // dropped
);
    t_item w_in, w_q;
    logic w_full, w_empty, w_pop;
    assign w_in = '{value: s_axis_tdata, is_last: s_axis_tlast};
    assign s_axis_tready = !w_full;

    msort_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid), .i_item(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_item(w_q), .o_empty(w_empty)
    );

    msort_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(w_q), .i_empty(w_empty), .o_pop(w_pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(m_axis_tdata), .o_last(m_axis_tlast), .o_dropped(m_axis_tuser)
    );
endmodule
`default_nettype wire
